### design/pdens_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdens_pkg;

	// Fixed field widths of the stream items.
	localparam int COORD_W = 32;
	localparam int QUAT_W  = 16;
	localparam int SPACE_W = 31;

	// Operand width of the shared unit: a coordinate difference needs one extra bit.
	localparam int OPND_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * OPND_W;
	localparam int DEN_W   = 7;

	// Operation codes of the shared unit.
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
	} unit_cmd_t;

endpackage
`default_nettype wire

### design/pdens_iter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module pdens_iter_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pdens_pkg::unit_cmd_t              cmd,
	input  wire logic [pdens_pkg::OPND_W-1:0]      opa,
	input  wire logic [pdens_pkg::OPND_W-1:0]      opb,
	output logic                                   done,
	output logic [pdens_pkg::PROD_W-1:0]           prod,
	output logic [pdens_pkg::OPND_W-1:0]           quot,
	output logic [pdens_pkg::DEN_W-1:0]            rem
);

	localparam int CNT_W = $clog2(pdens_pkg::OPND_W + 1);

	logic                            busy_q;
	logic                            done_q;
	logic                            op_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [pdens_pkg::PROD_W-1:0]    acc_q;
	logic [pdens_pkg::PROD_W-1:0]    mcand_q;
	logic [pdens_pkg::OPND_W-1:0]    mplier_q;
	logic [pdens_pkg::DEN_W+1:0]     trial;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign trial = {1'b0, acc_q[pdens_pkg::DEN_W-1:0], mplier_q[pdens_pkg::OPND_W-1]}
		- {2'b0, mcand_q[pdens_pkg::DEN_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pdens_pkg::OPND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			acc_q <= '0;
			if (cmd.op == pdens_pkg::OP_MUL) begin
				mcand_q  <= {{pdens_pkg::OPND_W{1'b0}}, opa};
				mplier_q <= opb;
			end else begin
				mcand_q  <= {{(pdens_pkg::PROD_W-pdens_pkg::DEN_W){1'b0}},
					opb[pdens_pkg::DEN_W-1:0]};
				mplier_q <= opa;
			end
		end else if (busy_q) begin
			if (op_q == pdens_pkg::OP_MUL) begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end else begin
				if (!trial[pdens_pkg::DEN_W+1])
					acc_q <= pdens_pkg::PROD_W'(trial[pdens_pkg::DEN_W:0]);
				else
					acc_q <= pdens_pkg::PROD_W'({acc_q[pdens_pkg::DEN_W-1:0],
						mplier_q[pdens_pkg::OPND_W-1]});
				mplier_q <= {mplier_q[pdens_pkg::OPND_W-2:0], ~trial[pdens_pkg::DEN_W+1]};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quot = mplier_q;
	assign rem  = acc_q[pdens_pkg::DEN_W-1:0];

endmodule
`default_nettype wire

### design/path_point_densifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   tdata: waypoint pose, tuser: first_of_path
// m_*       out        m_tvalid/m_tready   tdata: point pose, tuser: flags, tlast: last_of_run
// cfg_*     in         cfg_valid/cfg_ready cfg_data: max_spacing
//
// A waypoint that starts a path, or comes with no previous pose, goes from the idle state
// straight to ST_CUR and into the output register. Any other waypoint goes through three
// squarings on the shared multiply/divide unit (33 shift-add steps each), a count search
// of one candidate per cycle (up to MAX_INTERMEDIATES) and, when intermediates are
// needed, two divisions and then ST_STEP and ST_INT for each intermediate point; ST_CUR
// then places the waypoint itself.
// Reset marks the previous pose as absent, restores the spacing register and empties the
// output register.
// The block takes no new item until the last result of the current one has been
// placed in the output register; a stalled output simply holds the sequencer for as long
// as the stall lasts.
module path_point_densifier_unit #(
	parameter int MAX_INTERMEDIATES = 63
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
	input  wire logic [159:0] s_tdata,
	// first_of_path
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_x, out_y, out_z, out_qx, out_qy, out_qz, out_qw
	output logic [159:0]      m_tdata,
	// is_intermediate, count_clipped
	output logic [1:0]        m_tuser,
	output logic              m_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [pdens_pkg::SPACE_W-1:0] cfg_data
);

	localparam int CW  = pdens_pkg::COORD_W;
	localparam int QW  = pdens_pkg::QUAT_W;
	localparam int OW  = pdens_pkg::OPND_W;
	localparam int DW  = pdens_pkg::DEN_W;
	localparam int D2W = pdens_pkg::PROD_W + 1;
	localparam int SQW = 76;
	localparam int QFW = CW + 3;
	localparam int JW  = DW - 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_KICK  = 4'd1;
	localparam logic [3:0] ST_SQX   = 4'd2;
	localparam logic [3:0] ST_SQY   = 4'd3;
	localparam logic [3:0] ST_SQS   = 4'd4;
	localparam logic [3:0] ST_CNT   = 4'd5;
	localparam logic [3:0] ST_DKICK = 4'd6;
	localparam logic [3:0] ST_DIVX  = 4'd7;
	localparam logic [3:0] ST_DIVY  = 4'd8;
	localparam logic [3:0] ST_STEP  = 4'd9;
	localparam logic [3:0] ST_INT   = 4'd10;
	localparam logic [3:0] ST_CUR   = 4'd11;

	logic [3:0]                   state_q;
	logic                         have_prev_q;
	logic [pdens_pkg::SPACE_W-1:0] spacing_q;
	logic [JW-1:0]                j_q;
	logic [JW-1:0]                n_q;
	logic                         clip_q;
	logic                         out_valid_q;

	// Current and previous poses.
	logic signed [CW-1:0] cur_x_q, cur_y_q, cur_z_q;
	logic [4*QW-1:0]      cur_q_q;
	logic signed [CW-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [4*QW-1:0]      prev_q_q;

	// Distance and count search.
	logic [D2W-1:0] d2_q;
	logic [SQW-1:0] sq_q;
	logic [SQW-1:0] inc_q;
	logic [SQW-1:0] s2x2_q;

	// Incremental interpolation: floor quotient and remainder for each axis.
	logic signed [QFW-1:0] qdx_q, qdy_q, qfx_q, qfy_q;
	logic [DW-1:0]         rdx_q, rdy_q, rx_q, ry_q;

	logic [159:0] out_data_q;
	logic [1:0]   out_user_q;
	logic         out_last_q;

	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic [OW-1:0]        dx, dy, ax, ay;
	logic [DW-1:0]        den;
	logic                 unit_done;
	logic [pdens_pkg::PROD_W-1:0] unit_prod;
	logic [OW-1:0]        unit_quot;
	logic [DW-1:0]        unit_rem;
	pdens_pkg::unit_cmd_t cmd;
	logic [OW-1:0]        opa, opb;
	logic                 fits;
	logic signed [QFW-1:0] qd_now;
	logic [DW-1:0]         rd_now;
	logic                  neg_now;
	logic [DW:0]           sumx, sumy;
	logic                  gex, gey;
	logic signed [QFW-1:0] tx, ty;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	// A result enters the output register whenever the emitting states find it free.
	assign out_load  = out_free && ((state_q == ST_INT) || (state_q == ST_CUR));

	// Differences to the previous pose and their magnitudes.
	assign dx  = {cur_x_q[CW-1], cur_x_q} - {prev_x_q[CW-1], prev_x_q};
	assign dy  = {cur_y_q[CW-1], cur_y_q} - {prev_y_q[CW-1], prev_y_q};
	assign ax  = dx[OW-1] ? (~dx + 1'b1) : dx;
	assign ay  = dy[OW-1] ? (~dy + 1'b1) : dy;
	assign den = {1'b0, n_q} + 1'b1;

	// The point is inside the allowed spacing once the candidate square reaches d^2.
	assign fits = (SQW'(d2_q) <= sq_q);

	// Commands are issued from ST_KICK and ST_DKICK, then as the previous operation finishes.
	always_comb begin
		cmd.start = 1'b0;
		cmd.op    = pdens_pkg::OP_MUL;
		opa       = ax;
		opb       = ax;
		unique case (state_q)
			ST_KICK: begin
				cmd.start = 1'b1;
			end
			ST_SQX: begin
				cmd.start = unit_done;
				opa       = ay;
				opb       = ay;
			end
			ST_SQY: begin
				cmd.start = unit_done;
				opa       = OW'(spacing_q);
				opb       = OW'(spacing_q);
			end
			ST_DKICK: begin
				cmd.start = 1'b1;
				cmd.op    = pdens_pkg::OP_DIV;
				opb       = OW'(den);
			end
			ST_DIVX: begin
				cmd.start = unit_done;
				cmd.op    = pdens_pkg::OP_DIV;
				opa       = ay;
				opb       = OW'(den);
			end
			default: begin
				cmd.start = 1'b0;
			end
		endcase
	end

	pdens_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.done   (unit_done),
		.prod   (unit_prod),
		.quot   (unit_quot),
		.rem    (unit_rem)
	);

	// Turn the magnitude division into a floor division of the signed difference.
	always_comb begin
		neg_now = (state_q == ST_DIVX) ? dx[OW-1] : dy[OW-1];
		if (!neg_now) begin
			qd_now = QFW'(unit_quot);
			rd_now = unit_rem;
		end else if (unit_rem == '0) begin
			qd_now = -QFW'(unit_quot);
			rd_now = '0;
		end else begin
			qd_now = -QFW'(unit_quot) - QFW'(1);
			rd_now = den - unit_rem;
		end
	end

	// Adding the per-step increment carries out of the remainder at most once.
	assign sumx = {1'b0, rx_q} + {1'b0, rdx_q};
	assign sumy = {1'b0, ry_q} + {1'b0, rdy_q};
	assign gex  = (sumx >= {1'b0, den});
	assign gey  = (sumy >= {1'b0, den});

	// Floor quotient to truncation toward zero.
	assign tx = qfx_q + QFW'(qfx_q[QFW-1] && (rx_q != '0));
	assign ty = qfy_q + QFW'(qfy_q[QFW-1] && (ry_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			spacing_q   <= pdens_pkg::SPACE_W'(13107);
			j_q         <= '0;
			n_q         <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				spacing_q <= cfg_data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						clip_q <= 1'b0;
						if (s_tuser[0] || !have_prev_q)
							state_q <= ST_CUR;
						else
							state_q <= ST_KICK;
					end
				end
				ST_KICK: state_q <= ST_SQX;
				ST_SQX: begin
					if (unit_done)
						state_q <= ST_SQY;
				end
				ST_SQY: begin
					if (unit_done)
						state_q <= ST_SQS;
				end
				ST_SQS: begin
					if (unit_done) begin
						j_q     <= JW'(1);
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					if (fits) begin
						if (j_q == JW'(1)) begin
							state_q <= ST_CUR;
						end else begin
							n_q     <= j_q;
							state_q <= ST_DKICK;
						end
					end else if (j_q == JW'(MAX_INTERMEDIATES)) begin
						n_q     <= JW'(MAX_INTERMEDIATES);
						clip_q  <= 1'b1;
						state_q <= ST_DKICK;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DKICK: state_q <= ST_DIVX;
				ST_DIVX: begin
					if (unit_done)
						state_q <= ST_DIVY;
				end
				ST_DIVY: begin
					if (unit_done) begin
						j_q     <= JW'(1);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: state_q <= ST_INT;
				ST_INT: begin
					if (out_free) begin
						if (j_q == n_q) begin
							state_q <= ST_CUR;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_STEP;
						end
					end
				end
				ST_CUR: begin
					if (out_free) begin
						have_prev_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= s_tdata[31:0];
			cur_y_q <= s_tdata[63:32];
			cur_z_q <= s_tdata[95:64];
			cur_q_q <= s_tdata[159:96];
		end
		if (state_q == ST_SQX && unit_done)
			d2_q <= D2W'(unit_prod);
		if (state_q == ST_SQY && unit_done)
			d2_q <= d2_q + D2W'(unit_prod);
		// Squares of j * spacing grow by spacing^2 * (2j + 1) from one j to the next.
		if (state_q == ST_SQS && unit_done) begin
			sq_q   <= SQW'(unit_prod);
			inc_q  <= SQW'(unit_prod) + (SQW'(unit_prod) << 1);
			s2x2_q <= SQW'(unit_prod) << 1;
		end
		if (state_q == ST_CNT) begin
			sq_q  <= sq_q + inc_q;
			inc_q <= inc_q + s2x2_q;
		end
		if (state_q == ST_DIVX && unit_done) begin
			qdx_q <= qd_now;
			rdx_q <= rd_now;
		end
		if (state_q == ST_DIVY && unit_done) begin
			qdy_q <= qd_now;
			rdy_q <= rd_now;
			qfx_q <= QFW'(prev_x_q);
			qfy_q <= QFW'(prev_y_q);
			rx_q  <= '0;
			ry_q  <= '0;
		end
		if (state_q == ST_STEP) begin
			rx_q  <= gex ? DW'(sumx - {1'b0, den}) : sumx[DW-1:0];
			ry_q  <= gey ? DW'(sumy - {1'b0, den}) : sumy[DW-1:0];
			qfx_q <= qfx_q + qdx_q + QFW'(gex);
			qfy_q <= qfy_q + qdy_q + QFW'(gey);
		end
		if (state_q == ST_INT && out_free) begin
			out_data_q <= {prev_q_q, prev_z_q, ty[CW-1:0], tx[CW-1:0]};
			out_user_q <= {clip_q, 1'b1};
			out_last_q <= 1'b0;
		end
		if (state_q == ST_CUR && out_free) begin
			out_data_q <= {cur_q_q, cur_z_q, cur_y_q, cur_x_q};
			out_user_q <= {clip_q, 1'b0};
			out_last_q <= 1'b1;
			prev_x_q   <= cur_x_q;
			prev_y_q   <= cur_y_q;
			prev_z_q   <= cur_z_q;
			prev_q_q   <= cur_q_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

### bench/path_point_densifier_unit_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Checks the path point densifier as a black box. Waypoints go in on the s_*
// stream and a local model of the block predicts every point it must emit:
// the intermediate points and then the waypoint itself. Each emitted item is
// compared field by field with the oldest predicted point. For most directed
// rows the number of points per waypoint is also written into the table, so
// that the count search is checked against a value worked out by hand.
module path_point_densifier_unit_test;

	localparam int COORD_W = pdens_pkg::COORD_W;
	localparam int QUAT_W = pdens_pkg::QUAT_W;
	localparam int SPACE_W = pdens_pkg::SPACE_W;

	localparam int MAX_POINTS = 63;
	localparam int IDLE_LIMIT = 40000;
	localparam int RANDOM_ITEMS = 200;
	localparam int NO_COUNT = -1;

	typedef enum logic {
		ROW_ITEM,
		ROW_SPACING
	} row_kind_t;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [QUAT_W-1:0] q[4];
		logic inter;
		logic last;
		logic clip;
	} point_t;

	typedef struct {
		row_kind_t kind;
		logic first;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [QUAT_W-1:0] qx;
		logic [QUAT_W-1:0] qy;
		logic [QUAT_W-1:0] qz;
		logic [QUAT_W-1:0] qw;
		int n_points;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [159:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [159:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [SPACE_W-1:0] cfg_data;

	path_point_densifier_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Predicted points in emission order, and the hand-worked point count of
	// each waypoint (NO_COUNT where the table gives none).
	point_t pending_points[$];
	int pending_counts[$];
	int failures = 0;

	// Local copy of the block's state and its spacing register.
	longint last_x, last_y, last_z;
	logic [QUAT_W-1:0] last_q[4];
	bit have_last;
	longint spacing;

	// Idle percentages of both sides, changed between phases.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint to_signed(logic [COORD_W-1:0] v);
		return longint'(signed'(v));
	endfunction

	// Works out every point one waypoint causes and updates the local pose.
	function automatic void densify_waypoint(logic first, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz, logic [QUAT_W-1:0] cq[4]);
		longint cx, cy, cz, dx, dy, den, ix, iy;
		logic [127:0] dist_sq, step_sq, ax, ay, ns;
		int n;
		logic clip;
		point_t p;
		cx = to_signed(px);
		cy = to_signed(py);
		cz = to_signed(pz);
		n = 0;
		clip = 1'b0;
		if (have_last && !first) begin
			dx = cx - last_x;
			dy = cy - last_y;
			ax = (dx < 0) ? 128'(-dx) : 128'(dx);
			ay = (dy < 0) ? 128'(-dy) : 128'(dy);
			dist_sq = ax * ax + ay * ay;
			step_sq = 128'(spacing) * 128'(spacing);
			if (dist_sq > step_sq) begin
				// Smallest count whose multiple of the spacing covers the distance.
				n = MAX_POINTS;
				clip = 1'b1;
				for (int j = 1; j <= MAX_POINTS; j++) begin
					ns = 128'(j) * 128'(spacing);
					if (!(dist_sq > ns * ns)) begin
						n = j;
						clip = 1'b0;
						break;
					end
				end
				den = n + 1;
				for (int j = 1; j <= n; j++) begin
					// Signed division truncates toward zero, as the block must.
					ix = (last_x * den + dx * j) / den;
					iy = (last_y * den + dy * j) / den;
					p.x = ix[COORD_W-1:0];
					p.y = iy[COORD_W-1:0];
					p.z = last_z[COORD_W-1:0];
					p.q = last_q;
					p.inter = 1'b1;
					p.last = 1'b0;
					p.clip = clip;
					pending_points = {pending_points, p};
				end
			end
		end
		p.x = px;
		p.y = py;
		p.z = pz;
		p.q = cq;
		p.inter = 1'b0;
		p.last = 1'b1;
		p.clip = clip;
		pending_points = {pending_points, p};
		last_x = cx;
		last_y = cy;
		last_z = cz;
		last_q = cq;
		have_last = 1'b1;
	endfunction

	// Offers one waypoint and returns once it has been taken.
	task automatic send_waypoint(logic first, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz, logic [QUAT_W-1:0] qx,
			logic [QUAT_W-1:0] qy, logic [QUAT_W-1:0] qz, logic [QUAT_W-1:0] qw,
			int n_points);
		logic [QUAT_W-1:0] cq[4];
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = first;
		s_tdata = {qw, qz, qy, qx, pz, py, px};
		do
			@(posedge clk);
		while (!s_tready);
		cq = '{qx, qy, qz, qw};
		densify_waypoint(first, px, py, pz, cq);
		pending_counts = {pending_counts, n_points};
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_for_all_points();
		while (pending_points.size() != 0)
			@(negedge clk);
		// Every waypoint ends in a point, so the block is idle by now and its ready
		// is already high; the extra wait only adds a gap.
		repeat (4) @(negedge clk);
	endtask

	task automatic write_spacing(logic [SPACE_W-1:0] value);
		wait_for_all_points();
		cfg_valid = 1'b1;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		spacing = longint'(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver stalls at random.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Output checker; the run goes on after a mismatch.
	int run_length = 0;
	always @(posedge clk) begin
		point_t p;
		point_t got;
		int want;
		if (m_tvalid && m_tready) begin
			got.x = m_tdata[31:0];
			got.y = m_tdata[63:32];
			got.z = m_tdata[95:64];
			got.q = '{m_tdata[111:96], m_tdata[127:112], m_tdata[143:128],
				m_tdata[159:144]};
			got.inter = m_tuser[0];
			got.clip = m_tuser[1];
			got.last = m_tlast;
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h", $time, got.x, got.y);
				failures++;
			end else begin
				p = pending_points.pop_front();
				if (got.x !== p.x || got.y !== p.y || got.z !== p.z) begin
					$display("%0t: position expected %h %h %h, got %h %h %h", $time,
						p.x, p.y, p.z, got.x, got.y, got.z);
					failures++;
				end
				if (got.q[0] !== p.q[0] || got.q[1] !== p.q[1] || got.q[2] !== p.q[2] ||
						got.q[3] !== p.q[3]) begin
					$display("%0t: quaternion expected %h %h %h %h, got %h %h %h %h",
						$time, p.q[0], p.q[1], p.q[2], p.q[3],
						got.q[0], got.q[1], got.q[2], got.q[3]);
					failures++;
				end
				if (got.inter !== p.inter || got.last !== p.last || got.clip !== p.clip)
						begin
					$display("%0t: flags inter/last/clip expected %b%b%b, got %b%b%b",
						$time, p.inter, p.last, p.clip, got.inter, got.last, got.clip);
					failures++;
				end
			end
			run_length++;
			if (m_tlast === 1'b1) begin
				if (pending_counts.size() != 0) begin
					want = pending_counts.pop_front();
					if (want != NO_COUNT && want != run_length) begin
						$display("%0t: point count expected %0d, got %0d", $time, want,
							run_length);
						failures++;
					end
				end
				run_length = 0;
			end
		end
	end

	// Watchdog on cycles in which no handshake completes.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Directed table. Items with a count were worked out by hand from the
	// spacing in force; the others rely on the local model alone.
	row_t directed[] = '{
		// A plain waypoint straight after reset counts as the start of a path.
		'{ROW_ITEM, 1'b0, 32'h0, 32'h0, 32'h5, 16'h1, 16'h2, 16'h3, 16'h4, 1},
		// Distance exactly equal to the spacing: no intermediates.
		'{ROW_ITEM, 1'b0, 32'd13107, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 1},
		// One unit further than the spacing: two intermediates.
		'{ROW_ITEM, 1'b0, 32'd26215, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 3},
		'{ROW_ITEM, 1'b0, 32'd26215, 32'd40000, 32'hffff0000, 16'h1234, 16'h8000,
			16'h7fff, 16'hffff, NO_COUNT},
		// Start of path at the top of every field.
		'{ROW_ITEM, 1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 1},
		// Jump to the bottom of every field: the count saturates.
		'{ROW_ITEM, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 64},
		// Same position again: zero distance.
		'{ROW_ITEM, 1'b0, 32'h80000000, 32'h80000000, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			1},
		'{ROW_ITEM, 1'b0, 32'hffffffff, 32'hfffffff0, 32'h1, 16'h5555, 16'haaaa,
			16'h0f0f, 16'hf0f0, 64},
		'{ROW_ITEM, 1'b0, 32'hfffd0000, 32'h00020000, 32'h1, 16'h0, 16'h0, 16'h0, 16'h0,
			NO_COUNT},
		// Zero spacing: any movement saturates, standing still gives nothing.
		'{ROW_SPACING, 1'b0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, NO_COUNT},
		'{ROW_ITEM, 1'b0, 32'hfffd0001, 32'h00020000, 32'h2, 16'h0, 16'h0, 16'h0, 16'h0,
			64},
		'{ROW_ITEM, 1'b0, 32'hfffd0001, 32'h00020000, 32'h3, 16'h1, 16'h0, 16'h0, 16'h0,
			1},
		// Largest spacing: a full-width jump along x is just over twice the spacing,
		// so it needs three intermediates.
		'{ROW_SPACING, 1'b0, 32'h7fffffff, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			NO_COUNT},
		'{ROW_ITEM, 1'b1, 32'h80000000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1},
		'{ROW_ITEM, 1'b0, 32'h7fffffff, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4},
		'{ROW_ITEM, 1'b0, 32'h80000000, 32'h80000000, 32'h0, 16'h0, 16'h0, 16'h0,
			16'h0, NO_COUNT},
		// Unit spacing: a short move gives a clean count.
		'{ROW_SPACING, 1'b0, 32'h1, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, NO_COUNT},
		'{ROW_ITEM, 1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1},
		'{ROW_ITEM, 1'b0, 32'h3, 32'h4, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6},
		'{ROW_ITEM, 1'b0, 32'hfffffff0, 32'h7, 32'h9, 16'h0, 16'h0, 16'h0, 16'h0,
			NO_COUNT}
	};

	// Random walk: mostly moves scaled to the spacing so that every count is
	// reached, with now and then a new path or a jump anywhere.
	task automatic send_random_waypoint();
		logic first;
		logic [COORD_W-1:0] px, py;
		longint span, dx, dy;
		int pick;
		pick = $urandom_range(99);
		first = (pick < 8);
		if (pick >= 88 || !have_last) begin
			px = $urandom;
			py = $urandom;
		end else begin
			span = spacing * $urandom_range(70) + 1;
			dx = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
			dy = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
			if ($urandom_range(3) == 0)
				dy = 0;
			px = COORD_W'(last_x + dx);
			py = COORD_W'(last_y + dy);
		end
		send_waypoint(first, px, py, $urandom, QUAT_W'($urandom), QUAT_W'($urandom),
			QUAT_W'($urandom), QUAT_W'($urandom), NO_COUNT);
	endtask

	initial begin
		logic [SPACE_W-1:0] settings[4];
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		last_x = 0;
		last_y = 0;
		last_z = 0;
		last_q = '{default: '0};
		have_last = 1'b0;
		spacing = 13107;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 19;
		recv_stall_pct = 57;
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_SPACING)
				write_spacing(directed[i].x[SPACE_W-1:0]);
			else
				send_waypoint(directed[i].first, directed[i].x, directed[i].y,
					directed[i].z, directed[i].qx, directed[i].qy, directed[i].qz,
					directed[i].qw, directed[i].n_points);
		end

		// Random part in phases: the spacing is written four times and the idling changes twice.
		settings = '{SPACE_W'(13107), SPACE_W'($urandom_range(1, 1000)),
			SPACE_W'(32'h00010000), SPACE_W'($urandom)};
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % (RANDOM_ITEMS / 4) == 0)
				write_spacing(settings[i / (RANDOM_ITEMS / 4)]);
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 57;
				recv_stall_pct = 19;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// Hold the sender back once until the output side has drained.
			if (i == RANDOM_ITEMS / 2)
				wait_for_all_points();
			send_random_waypoint();
		end

		wait_for_all_points();
		repeat (200) @(negedge clk);
		if (failures == 0 && pending_points.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
